// ===== hw/rtl/huffman_code_bit_packer_defines.svh =====
// ----------------------------------------------------------------------------
// huffman code bit packer assertion macros
// shared concurrent assertion forms for the packer rtl
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// same-cycle implication
`define HCBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbp same-cycle check failed");

// next-cycle implication
`define HCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbp next-cycle check failed");

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// types and constants shared by the huffman code bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int TOTAL_W      = 40;
  localparam int TABLE_DEPTH  = 256;
  localparam int ACC_W        = CODE_W + 7;

  localparam int LEN_LIMIT_I  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last;
    logic [2:0]         pad_bits;
    logic [TOTAL_W-1:0] total_bits;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [SYM_W-1:0] addr;
    entry_t           wr_entry;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// an accepted item has its table read registered, then its results load the result stage
// throughput: one item per cycle for items with at most one result, while result_stall is low
// an encode item with n bytes holds the result stage; one byte per cycle while not stalled
// reset: synchronous, clears the pending bits, bit total and all 256 table valid bits at once
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// table-driven variable-length encoder packing code bits msb first into bytes
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire hcbp_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output hcbp_pkg::result_t     result
);

  logic                       item_accept;
  logic                       result_accept;
  hcbp_pkg::tbl_req_t         tbl_req;
  hcbp_pkg::entry_t           entry;
  logic [hcbp_pkg::LEN_W-1:0] wr_len;
  logic [hcbp_pkg::CODE_W-1:0] wr_mask;

  logic       s1_valid;
  logic [1:0] s1_mode;
  logic       s1_adv;

  logic [6:0]                    partial_byte;
  logic [2:0]                    partial_count;
  logic [hcbp_pkg::TOTAL_W-1:0]  bit_total;
  logic [6:0]                    partial_byte_next;
  logic [2:0]                    partial_count_next;
  logic [hcbp_pkg::TOTAL_W-1:0]  bit_total_next;

  logic [7:0]                    burst_byte [4];
  logic [2:0]                    burst_cnt;
  logic [1:0]                    burst_idx;
  logic                          burst_flush;
  logic                          burst_bv;
  logic [2:0]                    burst_pad;
  logic [hcbp_pkg::TOTAL_W-1:0]  burst_total;
  logic                          burst_last;
  logic                          burst_free;

  logic [hcbp_pkg::ACC_W-1:0]    acc;
  logic [hcbp_pkg::ACC_W-1:0]    aligned;
  logic [5:0]                    nbits;
  logic [hcbp_pkg::TOTAL_W:0]    total_sum;
  logic [2:0]                    res_n;
  logic [7:0]                    res_byte [4];
  logic                          res_flush;
  logic                          res_bv;
  logic [2:0]                    res_pad;
  logic [hcbp_pkg::TOTAL_W-1:0]  res_total;

  // input side and table access
  assign item_accept = item_valid && !item_stall;
  assign item_stall  = s1_valid && !s1_adv;

  assign wr_len  = (item.code_length > hcbp_pkg::LEN_LIMIT) ? hcbp_pkg::LEN_LIMIT
                                                            : item.code_length;
  assign wr_mask = hcbp_pkg::CODE_W'((33'd1 << wr_len) - 33'd1);

  always_comb begin
    tbl_req.wr_en         = item_accept && (item.mode == hcbp_pkg::MODE_LOAD);
    tbl_req.rd_en         = item_accept && (item.mode == hcbp_pkg::MODE_ENCODE);
    tbl_req.addr          = item.symbol;
    tbl_req.wr_entry.bits = item.code_bits & wr_mask;
    tbl_req.wr_entry.len  = wr_len;
  end

  hcbp_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_entry (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_mode <= item.mode;
    end
  end

  // packing
  always_comb begin
    acc       = ((hcbp_pkg::ACC_W)'(partial_byte) << entry.len)
                | (hcbp_pkg::ACC_W)'(entry.bits);
    nbits     = 6'(partial_count) + entry.len;
    aligned   = acc << (6'(hcbp_pkg::ACC_W) - nbits);
    total_sum = (hcbp_pkg::TOTAL_W+1)'(bit_total) + (hcbp_pkg::TOTAL_W+1)'(entry.len);

    partial_byte_next  = partial_byte;
    partial_count_next = partial_count;
    bit_total_next     = bit_total;
    res_n     = 3'd0;
    res_flush = 1'b0;
    res_bv    = 1'b1;
    res_pad   = 3'd0;
    res_total = '0;
    for (int k = 0; k < 4; k++) begin
      res_byte[k] = aligned[hcbp_pkg::ACC_W-1-8*k -: 8];
    end

    case (s1_mode)
      hcbp_pkg::MODE_ENCODE: begin
        if (entry.len != '0) begin
          res_n              = nbits[5:3];
          partial_count_next = nbits[2:0];
          partial_byte_next  = acc[6:0] & ~(7'h7f << nbits[2:0]);
          bit_total_next     = total_sum[hcbp_pkg::TOTAL_W] ? '1
                                                            : total_sum[hcbp_pkg::TOTAL_W-1:0];
        end
      end
      hcbp_pkg::MODE_FLUSH: begin
        res_n              = 3'd1;
        res_flush          = 1'b1;
        res_total          = bit_total;
        partial_byte_next  = 7'd0;
        partial_count_next = 3'd0;
        if (partial_count != 3'd0) begin
          res_pad     = 3'(4'd8 - 4'(partial_count));
          res_byte[0] = 8'(8'(partial_byte) << res_pad);
        end else begin
          res_bv      = 1'b0;
          res_byte[0] = 8'd0;
        end
      end
      default: begin
        res_n = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte  <= 7'd0;
      partial_count <= 3'd0;
      bit_total     <= '0;
    end else if (s1_adv) begin
      partial_byte  <= partial_byte_next;
      partial_count <= partial_count_next;
      bit_total     <= bit_total_next;
    end
  end

  // result stage
  assign burst_last    = (3'(burst_idx) == (burst_cnt - 3'd1));
  assign result_valid  = (burst_cnt != 3'd0);
  assign result_accept = result_valid && !result_stall;
  assign burst_free    = (burst_cnt == 3'd0) || (result_accept && burst_last);
  assign s1_adv        = s1_valid && burst_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= 3'd0;
      burst_idx <= 2'd0;
    end else if (s1_adv && (res_n != 3'd0)) begin
      burst_cnt <= res_n;
      burst_idx <= 2'd0;
    end else if (result_accept) begin
      if (burst_last) begin
        burst_cnt <= 3'd0;
        burst_idx <= 2'd0;
      end else begin
        burst_idx <= burst_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (res_n != 3'd0)) begin
      burst_byte  <= res_byte;
      burst_flush <= res_flush;
      burst_bv    <= res_bv;
      burst_pad   <= res_pad;
      burst_total <= res_total;
    end
  end

  always_comb begin
    result.out_byte   = burst_byte[burst_idx];
    result.byte_valid = burst_flush ? burst_bv : 1'b1;
    result.last       = burst_last;
    result.pad_bits   = burst_pad;
    result.total_bits = burst_total;
  end

  `HCBP_ASSERT_IMPL(a_idx_in_burst, burst_cnt != 3'd0, 3'(burst_idx) < burst_cnt)
  `HCBP_ASSERT_IMPL(a_cnt_range, burst_cnt != 3'd0, burst_cnt <= 3'd4)
  `HCBP_ASSERT_IMPL(a_no_overrun, item_accept, !s1_valid || s1_adv)
  `HCBP_ASSERT_NEXT(a_flush_clears, s1_adv && (s1_mode == hcbp_pkg::MODE_FLUSH),
                    partial_count == 3'd0)

endmodule

`default_nettype wire

// ===== hw/rtl/hcbp_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_table
// code table memory with per-entry valid bits and a registered read
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hcbp_pkg::tbl_req_t req,
  output hcbp_pkg::entry_t        rd_entry
);

  hcbp_pkg::entry_t                     mem [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::TABLE_DEPTH-1:0]     filled;
  hcbp_pkg::entry_t                     mem_q;
  logic                                 hit_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_entry;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        filled[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_q <= filled[req.addr];
      end
    end
  end

  // entries never loaded read as an empty code
  assign rd_entry = hit_q ? mem_q : '0;

endmodule

`default_nettype wire
